// File: rtl/brf_pkg.sv
package brf_pkg;

   localparam int CNT_W = 10;
   localparam int BYTE_W = 8;

   localparam logic [1:0] CSR_CAPACITY_ADDR = 2'd0;
   localparam logic [CNT_W-1:0] CAPACITY_RESET = 10'd1023;

   typedef enum logic [2:0] {
      OP_WRITE   = 3'd0,
      OP_DEQUEUE = 3'd1,
      OP_PEEK    = 3'd2,
      OP_DISCARD = 3'd3,
      OP_CLEAR   = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      STATUS_OK         = 3'd0,
      STATUS_BAD_LEN    = 3'd1,
      STATUS_NO_SPACE   = 3'd2,
      STATUS_NO_DATA    = 3'd3,
      STATUS_NO_BURST   = 3'd4,
      STATUS_BURST_OPEN = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_REPLY,
      ST_FETCH,
      ST_BYTE
   } state_type;

endpackage

// File: rtl/byte_ring_fifo_top.sv
// Circular byte FIFO with one slot always left empty, so the ring holds
// capacity plus one slots and the front and rear indices wrap at that size.
// The block takes one word at a time and is not ready while a word is being
// answered. A write byte, discard, clear or rejected request is accepted and its
// single reply word is offered in the next cycle. A successful dequeue or peek
// of N bytes passes through ST_FETCH and ST_BYTE for each byte: the single-port
// storage memory is read in ST_FETCH and the registered byte is offered in the
// next cycle, in ST_BYTE. Every index step goes through one shared modular adder.
// Storage contents are undefined until written and need no clearing pass after
// reset. Writing the capacity register also empties the FIFO and closes any
// open burst; it is meant to be written only when idle.
module byte_ring_fifo_top
   import brf_pkg::*;
#(
   parameter int STORE_DEPTH = 1024,
   parameter int MAX_READ = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // Fields from bit 0: length[9:0], data_byte[17:10], zero padding.
   input  logic [23:0] req_tdata,
   // Fields from bit 0: op[2:0], first[3].
   input  logic [3:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // Fields from bit 0: read_byte[7:0], used_count[17:8], zero padding.
   output logic [23:0] rsp_tdata,
   // Fields from bit 0: status[2:0].
   output logic [2:0]  rsp_tuser,
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int LEFT_W = $clog2(MAX_READ + 1);
   localparam int CAP_HI = (STORE_DEPTH - 1 > 1023) ? 1023 : STORE_DEPTH - 1;

   state_type              state_ff, state_in;
   logic [CNT_W-1:0]       capacity_ff, capacity_in;
   logic [CNT_W-1:0]       front_ff, front_in;
   logic [CNT_W-1:0]       rear_ff, rear_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [CNT_W-1:0]       burst_rem_ff, burst_rem_in;
   logic                   burst_open_ff, burst_open_in;
   logic [CNT_W-1:0]       rd_idx_ff, rd_idx_in;
   logic [LEFT_W-1:0]      rd_left_ff, rd_left_in;
   status_type             status_ff, status_in;
   logic [BYTE_W-1:0]      rdata_ff;

   logic [BYTE_W-1:0]      mem [STORE_DEPTH];
   logic                   mem_we;
   logic                   mem_re;
   logic [CNT_W-1:0]       mem_idx;
   logic [ADDR_W+CNT_W-1:0] mem_idx_wide;
   logic [ADDR_W-1:0]      mem_addr;

   logic [CNT_W-1:0]       eff_cap;
   logic [CNT_W-1:0]       add_a, add_b, add_q;
   logic [CNT_W:0]         add_sum, add_mod;

   logic                   req_fire, rsp_fire, csr_write;
   op_type                 req_op;
   logic [CNT_W-1:0]       req_len;
   logic [BYTE_W-1:0]      req_byte;
   logic                   req_first;

   assign req_len   = req_tdata[CNT_W-1:0];
   assign req_byte  = req_tdata[CNT_W+BYTE_W-1:CNT_W];
   assign req_op    = op_type'(req_tuser[2:0]);
   assign req_first = req_tuser[3];
   assign req_fire  = req_tvalid && req_tready;
   assign rsp_fire  = rsp_tvalid && rsp_tready;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      if (capacity_ff == '0) begin
         eff_cap = CNT_W'(1);
      end else if (capacity_ff > CNT_W'(CAP_HI)) begin
         eff_cap = CNT_W'(CAP_HI);
      end else begin
         eff_cap = capacity_ff;
      end
   end

   // Shared modular adder for every index step.
   always_comb begin
      if (state_ff == ST_FETCH) begin
         add_a = rd_idx_ff;
         add_b = CNT_W'(1);
      end else if (req_op == OP_WRITE) begin
         add_a = rear_ff;
         add_b = CNT_W'(1);
      end else begin
         add_a = front_ff;
         add_b = req_len;
      end
      add_sum = {1'b0, add_a} + {1'b0, add_b};
      add_mod = {1'b0, eff_cap} + (CNT_W+1)'(1);
      if (add_sum >= add_mod) begin
         add_q = CNT_W'(add_sum - add_mod);
      end else begin
         add_q = add_sum[CNT_W-1:0];
      end
   end

   always_comb begin
      state_in      = state_ff;
      capacity_in   = capacity_ff;
      front_in      = front_ff;
      rear_in       = rear_ff;
      count_in      = count_ff;
      burst_rem_in  = burst_rem_ff;
      burst_open_in = burst_open_ff;
      rd_idx_in     = rd_idx_ff;
      rd_left_in    = rd_left_ff;
      status_in     = status_ff;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      mem_idx       = rear_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_REPLY;
               case (req_op)
                  OP_WRITE: begin
                     if (req_first) begin
                        if (burst_open_ff) begin
                           status_in = STATUS_BURST_OPEN;
                        end else if (req_len == '0 || req_len > eff_cap) begin
                           status_in = STATUS_BAD_LEN;
                        end else if (req_len > eff_cap - count_ff) begin
                           status_in = STATUS_NO_SPACE;
                        end else begin
                           status_in     = STATUS_OK;
                           mem_we        = 1'b1;
                           rear_in       = add_q;
                           count_in      = count_ff + CNT_W'(1);
                           burst_rem_in  = req_len - CNT_W'(1);
                           burst_open_in = req_len != CNT_W'(1);
                        end
                     end else begin
                        if (!burst_open_ff) begin
                           status_in = STATUS_NO_BURST;
                        end else begin
                           status_in     = STATUS_OK;
                           mem_we        = 1'b1;
                           rear_in       = add_q;
                           count_in      = count_ff + CNT_W'(1);
                           burst_rem_in  = burst_rem_ff - CNT_W'(1);
                           burst_open_in = burst_rem_ff != CNT_W'(1);
                        end
                     end
                  end
                  OP_CLEAR: begin
                     if (burst_open_ff) begin
                        status_in = STATUS_BURST_OPEN;
                     end else begin
                        status_in    = STATUS_OK;
                        front_in     = '0;
                        rear_in      = '0;
                        count_in     = '0;
                        burst_rem_in = '0;
                     end
                  end
                  OP_DISCARD: begin
                     if (burst_open_ff) begin
                        status_in = STATUS_BURST_OPEN;
                     end else if (req_len == '0 || req_len > eff_cap) begin
                        status_in = STATUS_BAD_LEN;
                     end else if (req_len > count_ff) begin
                        status_in = STATUS_NO_DATA;
                     end else begin
                        status_in = STATUS_OK;
                        front_in  = add_q;
                        count_in  = count_ff - req_len;
                     end
                  end
                  OP_DEQUEUE, OP_PEEK: begin
                     if (burst_open_ff) begin
                        status_in = STATUS_BURST_OPEN;
                     end else if (req_len == '0 || req_len > CNT_W'(MAX_READ)
                                  || req_len > eff_cap) begin
                        status_in = STATUS_BAD_LEN;
                     end else if (req_len > count_ff) begin
                        status_in = STATUS_NO_DATA;
                     end else begin
                        state_in   = ST_FETCH;
                        status_in  = STATUS_OK;
                        rd_idx_in  = front_ff;
                        rd_left_in = req_len[LEFT_W-1:0];
                        if (req_op == OP_DEQUEUE) begin
                           front_in = add_q;
                           count_in = count_ff - req_len;
                        end
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_REPLY: begin
            if (rsp_fire) begin
               state_in = ST_IDLE;
            end
         end
         ST_FETCH: begin
            mem_re    = 1'b1;
            mem_idx   = rd_idx_ff;
            rd_idx_in = add_q;
            state_in  = ST_BYTE;
         end
         ST_BYTE: begin
            if (rsp_fire) begin
               rd_left_in = rd_left_ff - LEFT_W'(1);
               if (rd_left_ff == LEFT_W'(1)) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_FETCH;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (csr_write && csr_paddr == CSR_CAPACITY_ADDR) begin
         capacity_in   = csr_pwdata[CNT_W-1:0];
         front_in      = '0;
         rear_in       = '0;
         count_in      = '0;
         burst_rem_in  = '0;
         burst_open_in = 1'b0;
      end
   end

   always_comb begin
      req_tready = state_ff == ST_IDLE;
      rsp_tvalid = (state_ff == ST_REPLY) || (state_ff == ST_BYTE);
      rsp_tuser  = status_ff;
      if (state_ff == ST_BYTE) begin
         rsp_tlast = rd_left_ff == LEFT_W'(1);
         rsp_tdata = {6'd0, count_ff, rdata_ff};
      end else begin
         rsp_tlast = 1'b1;
         rsp_tdata = {6'd0, count_ff, 8'd0};
      end
      csr_pready = 1'b1;
      if (csr_paddr == CSR_CAPACITY_ADDR) begin
         csr_prdata = {22'd0, capacity_ff};
      end else begin
         csr_prdata = '0;
      end
   end

   assign mem_idx_wide = {{ADDR_W{1'b0}}, mem_idx};
   assign mem_addr     = mem_idx_wide[ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= req_byte;
      end
      if (mem_re) begin
         rdata_ff <= mem[mem_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         capacity_ff   <= CAPACITY_RESET;
         front_ff      <= '0;
         rear_ff       <= '0;
         count_ff      <= '0;
         burst_rem_ff  <= '0;
         burst_open_ff <= 1'b0;
         rd_left_ff    <= '0;
      end else begin
         state_ff      <= state_in;
         capacity_ff   <= capacity_in;
         front_ff      <= front_in;
         rear_ff       <= rear_in;
         count_ff      <= count_in;
         burst_rem_ff  <= burst_rem_in;
         burst_open_ff <= burst_open_in;
         rd_left_ff    <= rd_left_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= rd_idx_in;
      status_ff <= status_in;
   end

`ifndef ASSERT_OFF
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= eff_cap && front_ff <= eff_cap && rear_ff <= eff_cap)
      else $error("ring index or count beyond the effective capacity");

   assert property (@(posedge clock) disable iff (reset)
      burst_open_ff |-> burst_rem_ff != '0)
      else $error("burst open with nothing left to write");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FETCH || state_ff == ST_BYTE) |-> rd_left_ff != '0)
      else $error("read sequence running with no bytes left");

   assert property (@(posedge clock) disable iff (reset)
      csr_write && csr_paddr == CSR_CAPACITY_ADDR |=> count_ff == '0 && !burst_open_ff)
      else $error("capacity write did not empty the FIFO");

   assert property (@(posedge clock) disable iff (reset)
      burst_open_ff && !$past(burst_open_ff) && !$past(reset) |-> $past(count_ff) < count_ff
      || $past(csr_write))
      else $error("burst opened without storing a byte");
`endif

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import brf_pkg::*;

   localparam int RING_SLOTS = 1024;
   localparam int MAX_READ_BYTES = 64;
   localparam int QUIET_LIMIT = 5000;
   localparam int HOLD_CYCLES = 300;
   localparam int SETTLE_CYCLES = 8;
   localparam int PHASE_WORDS = 56;

   typedef struct packed {
      logic [2:0] op;
      logic [9:0] len;
      logic [7:0] data;
      logic       first;
   } request_type;

   typedef struct packed {
      status_type status;
      logic [7:0] read_byte;
      logic       last;
      logic [9:0] used;
   } reply_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // Fields from bit 0: length[9:0], data_byte[17:10], zero padding.
   logic [23:0] req_tdata = '0;
   // Fields from bit 0: op[2:0], first[3].
   logic [3:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // Fields from bit 0: read_byte[7:0], used_count[17:8], zero padding.
   logic [23:0] rsp_tdata;
   // Fields from bit 0: status[2:0].
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [1:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   byte_ring_fifo_top #(
      .STORE_DEPTH(RING_SLOTS),
      .MAX_READ(MAX_READ_BYTES)
   ) u_top (.*);

   // Index 0 tracks the block as words are accepted; index 1 tracks the
   // stimulus as it is generated, so that sequences can be shaped ahead.
   logic [7:0]  ring_mem [2][RING_SLOTS];
   logic [9:0]  cap_reg [2];
   int unsigned front_idx [2];
   int unsigned rear_idx [2];
   int unsigned fill [2];
   int unsigned burst_left [2];
   bit          burst_on [2];

   request_type request_q [$];
   reply_type   reply_q [$];

   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned hold_token = 0;
   int unsigned hold_seen = 0;
   int unsigned hold_left = 0;
   int unsigned quiet_cycles = 0;
   int unsigned phase_words = 0;
   int unsigned fail_count = 0;
   int unsigned sent_words = 0;
   int unsigned checked_words = 0;
   int unsigned read_words = 0;
   int unsigned refused_words = 0;
   int unsigned cap_writes = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
   end

   function automatic int unsigned eff_cap(int m);
      return (cap_reg[m] == 0) ? 1 : cap_reg[m];
   endfunction

   function automatic void ring_empty(int m);
      front_idx[m] = 0;
      rear_idx[m] = 0;
      fill[m] = 0;
      burst_left[m] = 0;
      burst_on[m] = 1'b0;
   endfunction

   function automatic void expect_reply(int m, status_type s, logic [7:0] b, logic l);
      reply_type r;
      if (m == 0) begin
         r.status = s;
         r.read_byte = b;
         r.last = l;
         r.used = 10'(fill[m]);
         reply_q.push_back(r);
         if (s != STATUS_OK) refused_words++;
      end
   endfunction

   function automatic void apply_request(int m, logic [2:0] op, logic [9:0] len,
                                         logic [7:0] data, logic first);
      int unsigned cap;
      int unsigned idx;
      logic [7:0]  got [MAX_READ_BYTES];
      cap = eff_cap(m);
      if (op > OP_CLEAR) return;
      if (op == OP_WRITE) begin
         if (first && burst_on[m]) begin
            expect_reply(m, STATUS_BURST_OPEN, 8'd0, 1'b1);
         end else if (first && (len == 0 || len > cap)) begin
            expect_reply(m, STATUS_BAD_LEN, 8'd0, 1'b1);
         end else if (first && len > cap - fill[m]) begin
            expect_reply(m, STATUS_NO_SPACE, 8'd0, 1'b1);
         end else if (!first && !burst_on[m]) begin
            expect_reply(m, STATUS_NO_BURST, 8'd0, 1'b1);
         end else begin
            ring_mem[m][rear_idx[m]] = data;
            rear_idx[m] = (rear_idx[m] + 1) % (cap + 1);
            fill[m]++;
            burst_left[m] = first ? int'(len) - 1 : burst_left[m] - 1;
            burst_on[m] = burst_left[m] != 0;
            expect_reply(m, STATUS_OK, 8'd0, 1'b1);
         end
      end else if (burst_on[m]) begin
         expect_reply(m, STATUS_BURST_OPEN, 8'd0, 1'b1);
      end else if (op == OP_CLEAR) begin
         ring_empty(m);
         expect_reply(m, STATUS_OK, 8'd0, 1'b1);
      end else if (len == 0 || len > cap || (op != OP_DISCARD && len > MAX_READ_BYTES)) begin
         expect_reply(m, STATUS_BAD_LEN, 8'd0, 1'b1);
      end else if (len > fill[m]) begin
         expect_reply(m, STATUS_NO_DATA, 8'd0, 1'b1);
      end else if (op == OP_DISCARD) begin
         front_idx[m] = (front_idx[m] + len) % (cap + 1);
         fill[m] -= len;
         expect_reply(m, STATUS_OK, 8'd0, 1'b1);
      end else begin
         idx = front_idx[m];
         for (int k = 0; k < len; k++) begin
            got[k] = ring_mem[m][idx];
            idx = (idx + 1) % (cap + 1);
         end
         if (op == OP_DEQUEUE) begin
            front_idx[m] = idx;
            fill[m] -= len;
         end
         for (int k = 0; k < len; k++) begin
            expect_reply(m, STATUS_OK, got[k], k + 1 == len);
            if (m == 0) read_words++;
         end
      end
   endfunction

   function automatic void send_word(logic [2:0] op, logic [9:0] len, logic [7:0] data,
                                     logic first);
      request_type w;
      w.op = op;
      w.len = len;
      w.data = data;
      w.first = first;
      request_q.push_back(w);
      apply_request(1, op, len, data, first);
      if (op <= OP_CLEAR) phase_words++;
   endfunction

   function automatic void gen_sequence();
      int unsigned sel;
      int unsigned cap;
      int unsigned room;
      int unsigned lim;
      int unsigned n;
      int unsigned k;
      logic [2:0]  op;
      logic        first;
      logic [9:0]  len;
      sel = $urandom_range(99);
      cap = eff_cap(1);
      room = cap - fill[1];
      if (sel < 40 && room > 0) begin
         lim = (room > 16) ? 16 : room;
         if ($urandom_range(19) == 0) lim = (room > 200) ? 200 : room;
         n = $urandom_range(1, lim);
         for (int j = 0; j < n; j++)
            send_word(OP_WRITE, (j == 0) ? 10'(n) : 10'($urandom), 8'($urandom), j == 0);
      end else if (sel < 65 && fill[1] > 0) begin
         lim = (fill[1] > MAX_READ_BYTES) ? MAX_READ_BYTES : fill[1];
         op = (sel < 55) ? OP_DEQUEUE : OP_PEEK;
         send_word(op, 10'($urandom_range(1, lim)), 8'($urandom), 1'($urandom_range(1)));
      end else if (sel < 73 && fill[1] > 0) begin
         send_word(OP_DISCARD, 10'($urandom_range(1, fill[1])), 8'($urandom),
                   1'($urandom_range(1)));
      end else if (sel < 76) begin
         send_word(OP_CLEAR, 10'($urandom), 8'($urandom), 1'($urandom_range(1)));
      end else if (sel < 84 && room >= 2) begin
         n = $urandom_range(2, (room > 12) ? 12 : room);
         k = $urandom_range(1, n - 1);
         for (int j = 0; j < n; j++) begin
            if (j == k) begin
               if ($urandom_range(1))
                  send_word(3'($urandom_range(OP_DEQUEUE, OP_CLEAR)), 10'($urandom),
                            8'($urandom), 1'($urandom_range(1)));
               else
                  send_word(OP_WRITE, 10'($urandom_range(1, 5)), 8'($urandom), 1'b1);
            end
            send_word(OP_WRITE, (j == 0) ? 10'(n) : 10'($urandom), 8'($urandom), j == 0);
         end
      end else begin
         op = 3'($urandom_range(7));
         first = 1'($urandom_range(1));
         if (op == OP_WRITE && first)
            len = (room < RING_SLOTS - 1) ? 10'($urandom_range(room + 1, RING_SLOTS - 1))
                                          : 10'd0;
         else if ($urandom_range(1))
            len = 10'($urandom_range(70));
         else
            len = 10'($urandom);
         send_word(op, len, 8'($urandom), first);
      end
      while (burst_on[1])
         send_word(OP_WRITE, 10'($urandom), 8'($urandom), 1'b0);
   endfunction

   task automatic wait_drained();
      do @(negedge clock);
      while (request_q.size() != 0 || req_tvalid || reply_q.size() != 0);
   endtask

   task automatic wait_idle();
      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_check(logic [9:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b0;
      csr_penable <= 1'b0;
      csr_paddr <= CSR_CAPACITY_ADDR;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock);
      while (!csr_pready);
      if (csr_prdata[9:0] !== value) begin
         $display("%0t: capacity read expected %0d, got %0d", $time, value, csr_prdata[9:0]);
         fail_count++;
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic csr_write(logic [9:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= CSR_CAPACITY_ADDR;
      csr_pwdata <= {22'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock);
      while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      for (int m = 0; m < 2; m++) begin
         cap_reg[m] = value;
         ring_empty(m);
      end
      cap_writes++;
      csr_check(value);
   endtask

   always @(posedge clock) begin
      request_type w;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            apply_request(0, req_tuser[2:0], req_tdata[9:0], req_tdata[17:10], req_tuser[3]);
            sent_words++;
         end
         if (!req_tvalid || req_tready) begin
            if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               w = request_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {6'd0, w.data, w.len};
               req_tuser <= {w.first, w.op};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      reply_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (reply_q.size() == 0) begin
               $display("%0t: unexpected word, status %0d byte %0h last %0b count %0d",
                        $time, rsp_tuser, rsp_tdata[7:0], rsp_tlast, rsp_tdata[17:8]);
               fail_count++;
            end else begin
               want = reply_q.pop_front();
               checked_words++;
               if (rsp_tuser !== 3'(want.status)) begin
                  $display("%0t: status expected %0d, got %0d", $time, want.status, rsp_tuser);
                  fail_count++;
               end
               if (rsp_tdata[7:0] !== want.read_byte) begin
                  $display("%0t: read byte expected %0h, got %0h",
                           $time, want.read_byte, rsp_tdata[7:0]);
                  fail_count++;
               end
               if (rsp_tlast !== want.last) begin
                  $display("%0t: last expected %0b, got %0b", $time, want.last, rsp_tlast);
                  fail_count++;
               end
               if (rsp_tdata[17:8] !== want.used) begin
                  $display("%0t: used count expected %0d, got %0d",
                           $time, want.used, rsp_tdata[17:8]);
                  fail_count++;
               end
            end
         end
         if (hold_token != hold_seen) begin
            hold_seen = hold_token;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      logic [9:0] cap_value;
      for (int m = 0; m < 2; m++) begin
         cap_reg[m] = CAPACITY_RESET;
         ring_empty(m);
      end
      wait (!reset);
      @(negedge clock);
      csr_check(CAPACITY_RESET);

      send_word(OP_DEQUEUE, 10'd1, 8'h00, 1'b0);
      send_word(OP_WRITE, 10'd0, 8'h5A, 1'b0);
      send_word(OP_WRITE, 10'd0, 8'h00, 1'b1);
      send_word(OP_WRITE, 10'd3, 8'h00, 1'b1);
      send_word(OP_WRITE, 10'h3FF, 8'hFF, 1'b0);
      send_word(OP_PEEK, 10'd1, 8'h00, 1'b0);
      send_word(OP_WRITE, 10'd1, 8'h11, 1'b1);
      send_word(OP_CLEAR, 10'd0, 8'h00, 1'b0);
      send_word(OP_DISCARD, 10'd1, 8'h00, 1'b0);
      send_word(OP_DEQUEUE, 10'd1, 8'h00, 1'b0);
      send_word(OP_WRITE, 10'd0, 8'hA5, 1'b0);
      send_word(OP_WRITE, 10'h3FF, 8'h22, 1'b1);
      send_word(OP_PEEK, 10'd3, 8'h00, 1'b0);
      send_word(OP_DEQUEUE, 10'(MAX_READ_BYTES + 1), 8'h00, 1'b0);
      send_word(OP_PEEK, 10'd0, 8'h00, 1'b0);
      send_word(OP_DEQUEUE, 10'd4, 8'h00, 1'b0);
      send_word(OP_DISCARD, 10'd0, 8'h00, 1'b0);
      send_word(OP_DISCARD, 10'h3FF, 8'h00, 1'b0);
      for (int k = OP_CLEAR + 1; k < 8; k++)
         send_word(3'(k), 10'h3FF, 8'hFF, 1'b1);
      send_word(OP_DEQUEUE, 10'd2, 8'h00, 1'b0);
      send_word(OP_DISCARD, 10'd1, 8'h00, 1'b0);
      send_word(OP_CLEAR, 10'h3FF, 8'hFF, 1'b1);
      send_word(OP_DEQUEUE, 10'(MAX_READ_BYTES), 8'h00, 1'b0);

      for (int p = 0; p < 6; p++) begin
         wait_idle();
         case (p)
            0, 4: cap_value = CAPACITY_RESET;
            1: cap_value = 10'd1;
            2: cap_value = 10'd0;
            3: cap_value = 10'($urandom_range(8, 64));
            default: cap_value = 10'($urandom_range(65, 300));
         endcase
         csr_write(cap_value);
         send_idle_pct = (p % 4 == 1) ? 65 : (p % 4 == 3) ? 30 : 0;
         recv_stall_pct = (p % 4 == 2) ? 65 : (p % 4 == 3) ? 30 : 0;
         // The receiver holds off for a long stretch while the sender keeps offering.
         if (p == 4) hold_token++;
         phase_words = 0;
         while (phase_words < PHASE_WORDS / 2) gen_sequence();
         wait_drained();
         while (phase_words < PHASE_WORDS) gen_sequence();
         // Leave a burst open so that the next capacity write has to close it.
         if ((p == 0 || p == 3) && eff_cap(1) - fill[1] >= 3) begin
            send_word(OP_WRITE, 10'd3, 8'($urandom), 1'b1);
            send_word(OP_WRITE, 10'($urandom), 8'($urandom), 1'b0);
         end
      end

      wait_idle();
      repeat (20) @(negedge clock);
      $display("Covered %0d request words over %0d capacity writes, four idling patterns",
               sent_words, cap_writes);
      $display("and a long receiver hold-off; %0d reply words checked, %0d read bytes, %0d refusals.",
               checked_words, read_words, refused_words);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
